>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication or plain property on every clock outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> hw/rtl/hrse_pkg.sv
package hrse_pkg;

    localparam int ADDR_W = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_BYTES_PER_LINE = 2'd0;
    localparam logic [1:0] CFG_TOTAL_COUNT    = 2'd1;
    localparam logic [1:0] CFG_START_ADDRESS  = 2'd2;

    localparam logic [7:0] BPL_RESET = 8'd16;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] CHAR_FOUR  = 8'h34;
    localparam logic [7:0] CHAR_F     = 8'h46;

    // Sum of the fixed bytes of the start-segment record (04 0000 03)
    localparam logic [7:0] END_REC_SUM = 8'h07;

    // One unit of text work handed from the front end to the serializer
    typedef struct packed {
        logic              has_hdr;
        logic              has_data;
        logic              has_close;
        logic              has_end;
        logic [7:0]        rec_len;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [7:0]        close_ck;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [7:0]        end_ck;
    } hrse_job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'b0, nib};
        end else begin
            r = 8'h37 + {4'b0, nib};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/hrse_front.sv
module hrse_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [7:0]                s_data_byte,
    output logic                      job_valid,
    output hrse_pkg::hrse_job_t       job,
    input  logic                      job_take
);

    `include "assert_macros.svh"

    logic [7:0]  bpl_reg, bpl_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] start_reg, start_next;

    logic [15:0] bytes_done_reg, bytes_done_next;
    logic [7:0]  line_fill_reg, line_fill_next;
    logic [7:0]  line_length_reg, line_length_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic        finished_reg, finished_next;

    logic                job_valid_reg, job_valid_next;
    hrse_pkg::hrse_job_t job_reg, job_next;

    logic        acc;
    logic        line_open;
    logic [7:0]  bpl_eff;
    logic [15:0] remaining;
    logic [7:0]  new_len;
    logic [15:0] cur_addr;
    logic [7:0]  rec_len;
    logic [7:0]  sum_base;
    logic [7:0]  sum_new;
    logic [7:0]  fill_new;
    logic        rec_full;
    logic [7:0]  end_sum;

    function automatic logic [7:0] END_REC_SUM_F(input logic [15:0] sa, input logic [15:0] ea);
        return hrse_pkg::END_REC_SUM + sa[15:8] + sa[7:0] + ea[15:8] + ea[7:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !job_valid_reg || job_take;
    assign acc       = s_valid && s_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        bpl_eff   = (bpl_reg == 8'd0) ? 8'd1 : bpl_reg;
        remaining = total_reg - bytes_done_reg;
        new_len   = (remaining < {8'b0, bpl_eff}) ? remaining[7:0] : bpl_eff;
        cur_addr  = start_reg + bytes_done_reg;
        line_open = (line_fill_reg == 8'd0);
        rec_len   = line_open ? new_len : line_length_reg;
        sum_base  = line_open ? (new_len + cur_addr[15:8] + cur_addr[7:0]) : running_sum_reg;
        sum_new   = sum_base + s_data_byte;
        fill_new  = line_fill_reg + 8'd1;
        rec_full  = (fill_new >= rec_len);
        end_sum   = END_REC_SUM_F(start_reg, cur_addr);
    end

    always_comb begin
        bpl_next         = bpl_reg;
        total_next       = total_reg;
        start_next       = start_reg;
        bytes_done_next  = bytes_done_reg;
        line_fill_next   = line_fill_reg;
        line_length_next = line_length_reg;
        running_sum_next = running_sum_reg;
        finished_next    = finished_reg;
        job_valid_next   = job_take ? 1'b0 : job_valid_reg;
        job_next         = job_reg;

        if (cfg_valid) begin
            case (cfg_index)
                hrse_pkg::CFG_BYTES_PER_LINE: bpl_next   = cfg_data[7:0];
                hrse_pkg::CFG_TOTAL_COUNT:    total_next = cfg_data;
                hrse_pkg::CFG_START_ADDRESS:  start_next = cfg_data;
                default: ;
            endcase
        end

        if (acc && !finished_reg) begin
            if (!s_kind) begin
                if (bytes_done_reg < total_reg) begin
                    line_length_next    = rec_len;
                    bytes_done_next     = bytes_done_reg + 16'd1;
                    line_fill_next      = rec_full ? 8'd0 : fill_new;
                    running_sum_next    = rec_full ? 8'd0 : sum_new;
                    job_valid_next      = 1'b1;
                    job_next            = '0;
                    job_next.has_hdr    = line_open;
                    job_next.has_data   = 1'b1;
                    job_next.has_close  = rec_full;
                    job_next.rec_len    = rec_len;
                    job_next.addr       = cur_addr;
                    job_next.data       = s_data_byte;
                    job_next.close_ck   = ~sum_new + 8'd1;
                end
            end else begin
                if (bytes_done_reg >= total_reg) begin
                    // close a record left open by a lowered total first
                    line_fill_next       = 8'd0;
                    running_sum_next     = 8'd0;
                    finished_next        = 1'b1;
                    job_valid_next       = 1'b1;
                    job_next             = '0;
                    job_next.has_close   = !line_open;
                    job_next.has_end     = 1'b1;
                    job_next.close_ck    = ~running_sum_reg + 8'd1;
                    job_next.start_addr  = start_reg;
                    job_next.end_addr    = cur_addr;
                    job_next.end_ck      = ~end_sum + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpl_reg         <= hrse_pkg::BPL_RESET;
            total_reg       <= '0;
            start_reg       <= '0;
            bytes_done_reg  <= '0;
            line_fill_reg   <= '0;
            line_length_reg <= '0;
            running_sum_reg <= '0;
            finished_reg    <= 1'b0;
            job_valid_reg   <= 1'b0;
        end else begin
            bpl_reg         <= bpl_next;
            total_reg       <= total_next;
            start_reg       <= start_next;
            bytes_done_reg  <= bytes_done_next;
            line_fill_reg   <= line_fill_next;
            line_length_reg <= line_length_next;
            running_sum_reg <= running_sum_next;
            finished_reg    <= finished_next;
            job_valid_reg   <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

    `ASSERT_CLK(a_ready_when_empty, !job_valid_reg |-> s_ready, "input stalled with empty job slot")
    `ASSERT_CLK(a_finished_sticks, finished_reg |=> finished_reg, "finished flag cleared")
    `ASSERT_CLK(a_fill_below_len, (line_fill_reg != 8'd0) |-> (line_fill_reg < line_length_reg), "open record overfilled")

endmodule

>>> hw/rtl/hrse_serializer.sv
module hrse_serializer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      job_valid,
    input  hrse_pkg::hrse_job_t       job,
    output logic                      job_take,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_text_char,
    output logic                      m_last
);

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        PH_HDR,
        PH_DAT,
        PH_CLS,
        PH_END
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [5:0]          idx_reg, idx_next;
    logic                busy_reg, busy_next;
    hrse_pkg::hrse_job_t cur_reg, cur_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          char_reg, char_next;
    logic                last_reg, last_next;

    logic       out_adv;
    logic       emit;
    logic [5:0] phase_last_idx;
    logic       at_phase_end;
    logic       job_last;
    logic [7:0] cur_char;

    function automatic logic [7:0] text_at(input phase_t ph, input logic [5:0] i,
                                           input hrse_pkg::hrse_job_t j);
        logic [7:0] c;
        c = hrse_pkg::CHAR_ZERO;
        case (ph)
            PH_HDR: begin
                case (i)
                    6'd0:    c = hrse_pkg::CHAR_COLON;
                    6'd1:    c = hrse_pkg::hex_char(j.rec_len[7:4]);
                    6'd2:    c = hrse_pkg::hex_char(j.rec_len[3:0]);
                    6'd3:    c = hrse_pkg::hex_char(j.addr[15:12]);
                    6'd4:    c = hrse_pkg::hex_char(j.addr[11:8]);
                    6'd5:    c = hrse_pkg::hex_char(j.addr[7:4]);
                    6'd6:    c = hrse_pkg::hex_char(j.addr[3:0]);
                    default: c = hrse_pkg::CHAR_ZERO;
                endcase
            end
            PH_DAT: begin
                c = (i == 6'd0) ? hrse_pkg::hex_char(j.data[7:4])
                                : hrse_pkg::hex_char(j.data[3:0]);
            end
            PH_CLS: begin
                case (i)
                    6'd0:    c = hrse_pkg::hex_char(j.close_ck[7:4]);
                    6'd1:    c = hrse_pkg::hex_char(j.close_ck[3:0]);
                    6'd2:    c = hrse_pkg::CHAR_CR;
                    default: c = hrse_pkg::CHAR_LF;
                endcase
            end
            PH_END: begin
                case (i)
                    6'd0, 6'd21: c = hrse_pkg::CHAR_COLON;
                    6'd2:        c = hrse_pkg::CHAR_FOUR;
                    6'd8:        c = hrse_pkg::CHAR_THREE;
                    6'd9:        c = hrse_pkg::hex_char(j.start_addr[15:12]);
                    6'd10:       c = hrse_pkg::hex_char(j.start_addr[11:8]);
                    6'd11:       c = hrse_pkg::hex_char(j.start_addr[7:4]);
                    6'd12:       c = hrse_pkg::hex_char(j.start_addr[3:0]);
                    6'd13:       c = hrse_pkg::hex_char(j.end_addr[15:12]);
                    6'd14:       c = hrse_pkg::hex_char(j.end_addr[11:8]);
                    6'd15:       c = hrse_pkg::hex_char(j.end_addr[7:4]);
                    6'd16:       c = hrse_pkg::hex_char(j.end_addr[3:0]);
                    6'd17:       c = hrse_pkg::hex_char(j.end_ck[7:4]);
                    6'd18:       c = hrse_pkg::hex_char(j.end_ck[3:0]);
                    6'd19, 6'd32: c = hrse_pkg::CHAR_CR;
                    6'd20, 6'd33: c = hrse_pkg::CHAR_LF;
                    6'd29:       c = hrse_pkg::CHAR_ONE;
                    6'd30, 6'd31: c = hrse_pkg::CHAR_F;
                    default:     c = hrse_pkg::CHAR_ZERO;
                endcase
            end
            default: c = hrse_pkg::CHAR_ZERO;
        endcase
        return c;
    endfunction

    assign out_adv  = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_adv;
    assign job_take = job_valid && (!busy_reg || (emit && job_last));

    assign m_valid     = m_valid_reg;
    assign m_text_char = char_reg;
    assign m_last      = last_reg;

    always_comb begin
        case (phase_reg)
            PH_HDR:  phase_last_idx = 6'd8;
            PH_DAT:  phase_last_idx = 6'd1;
            PH_CLS:  phase_last_idx = 6'd3;
            PH_END:  phase_last_idx = 6'd33;
            default: phase_last_idx = 6'd0;
        endcase
        at_phase_end = (idx_reg == phase_last_idx);
        job_last = at_phase_end && ((phase_reg == PH_END)
                   || (phase_reg == PH_CLS && !cur_reg.has_end)
                   || (phase_reg == PH_DAT && !cur_reg.has_close));
        cur_char = text_at(phase_reg, idx_reg, cur_reg);
    end

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        busy_next    = busy_reg;
        cur_next     = cur_reg;
        m_valid_next = out_adv ? emit : m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;

        if (emit) begin
            char_next = cur_char;
            last_next = job_last;
            if (job_last) begin
                busy_next = 1'b0;
            end else if (at_phase_end) begin
                idx_next = 6'd0;
                case (phase_reg)
                    PH_HDR:  phase_next = PH_DAT;
                    PH_DAT:  phase_next = PH_CLS;
                    PH_CLS:  phase_next = PH_END;
                    default: phase_next = PH_END;
                endcase
            end else begin
                idx_next = idx_reg + 6'd1;
            end
        end

        if (job_take) begin
            busy_next = 1'b1;
            cur_next  = job;
            idx_next  = 6'd0;
            if (job.has_end) begin
                phase_next = job.has_close ? PH_CLS : PH_END;
            end else begin
                phase_next = job.has_hdr ? PH_HDR : PH_DAT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR;
            idx_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            cur_reg     <= cur_next;
            char_reg    <= char_next;
            last_reg    <= last_next;
        end
    end

    `ASSERT_CLK(a_job_has_work, busy_reg |-> (cur_reg.has_data || cur_reg.has_end), "empty job loaded")
    `ASSERT_CLK(a_idx_in_phase, busy_reg |-> (idx_reg <= phase_last_idx), "character index past phase end")
    `ASSERT_CLK(a_take_flags_last, (emit && job_last && !job_valid) |=> !busy_reg, "serializer kept busy after final character")

endmodule

>>> hw/rtl/hex_record_stream_encoder.sv
// Intel HEX text encoder.
// Input channel (s_valid/s_ready): s_kind 0 carries one data byte in s_data_byte,
// s_kind 1 asks for the end of the dump. Output channel (m_valid/m_ready): one
// ASCII character per word in m_text_char, m_last marks the final character
// caused by an input word. Configuration (cfg_valid/cfg_ready, always ready):
// cfg_index 0 bytes per line, 1 total byte count, 2 start address; write only
// while idle.
// A data byte gives 2 hex digits, plus a 9-character record header when it opens
// a record and checksum, CR, LF when it fills one: 2, 6, 11 or 15 characters.
// The end word gives the start-segment and end-of-file records, up to 38
// characters. Words that give no text are accepted without making a job.
// The word is registered in the job register; the serializer then loads it and
// registers its first character in the output register. Throughput: one
// character per cycle while the receiver is ready; a one-entry job register
// lets the next word be accepted while the current one is still being sent.
// Reset clears the byte count, open record and finished flag and sets 16 bytes
// per line. When the receiver stalls the character holds in the output register,
// the job register fills and s_ready drops until the serializer takes the job.
module hex_record_stream_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_text_char,
    output logic        m_last
);

    logic                job_valid;
    logic                job_take;
    hrse_pkg::hrse_job_t job;

    hrse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .job_valid   (job_valid),
        .job         (job),
        .job_take    (job_take)
    );

    hrse_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid),
        .job         (job),
        .job_take    (job_take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam bit         KIND_DATA   = 1'b0;
    localparam bit         KIND_END    = 1'b1;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         SETTLE      = 10;

    typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_DRAIN} row_op_t;

    // For word rows val[7:0] carries the data byte
    typedef struct packed {
        row_op_t     op;
        logic        kind;
        logic [1:0]  idx;
        logic [15:0] val;
    } plan_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } text_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_text_char;
    logic        m_last;

    // Encoder image: registers and record state
    logic [7:0]  cfg_bpl = hrse_pkg::BPL_RESET;
    logic [15:0] cfg_total = '0;
    logic [15:0] cfg_start = '0;
    logic [15:0] done_cnt = '0;
    logic [7:0]  fill = '0;
    logic [7:0]  rec_len = '0;
    logic [7:0]  ck_acc = '0;
    bit          dump_closed = 1'b0;

    logic [7:0]  step_text[$];
    text_char_t  expect_q[$];
    text_char_t  exp_c;

    plan_row_t   plan_q[$];
    string       plan_txt[$];

    int send_idle_pct = 20;
    int recv_idle_pct = 87;
    int err_count     = 0;
    int words_sent    = 0;
    int cfg_writes    = 0;
    int chars_checked = 0;
    int rand_bytes    = 0;
    int cycle_cnt     = 0;

    hex_record_stream_encoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] nib_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return hrse_pkg::CHAR_ZERO + {4'd0, n};
        end
        return 8'h41 + {4'd0, n} - 8'd10;
    endfunction

    function void emit(input logic [7:0] c);
        step_text.push_back(c);
    endfunction

    function void emit_hex(input logic [7:0] v);
        emit(nib_char(v[7:4]));
        emit(nib_char(v[3:0]));
    endfunction

    function void emit_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            emit(s[i]);
        end
    endfunction

    function void close_line(input logic [7:0] sum);
        emit_hex(8'h00 - sum);
        emit(hrse_pkg::CHAR_CR);
        emit(hrse_pkg::CHAR_LF);
    endfunction

    function void apply_cfg(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            hrse_pkg::CFG_BYTES_PER_LINE: cfg_bpl = val[7:0];
            hrse_pkg::CFG_TOTAL_COUNT:    cfg_total = val;
            hrse_pkg::CFG_START_ADDRESS:  cfg_start = val;
            default: ;
        endcase
    endfunction

    // Text that one input word turns into, left in step_text
    function void encode_word(input bit kind, input logic [7:0] b);
        logic [7:0]  bpl;
        logic [7:0]  len;
        logic [15:0] rem;
        logic [15:0] addr;
        logic [15:0] end_addr;
        logic [7:0]  sum;
        step_text.delete();
        if (dump_closed) return;
        if (kind == KIND_DATA) begin
            if (done_cnt >= cfg_total) return;
            if (fill == 8'd0) begin
                bpl = (cfg_bpl == 8'd0) ? 8'd1 : cfg_bpl;
                rem = cfg_total - done_cnt;
                len = (rem < {8'd0, bpl}) ? rem[7:0] : bpl;
                addr = cfg_start + done_cnt;
                rec_len = len;
                emit(hrse_pkg::CHAR_COLON);
                emit_hex(len);
                emit_hex(addr[15:8]);
                emit_hex(addr[7:0]);
                emit_hex(8'h00);
                ck_acc = len + addr[15:8] + addr[7:0];
            end
            emit_hex(b);
            ck_acc = ck_acc + b;
            fill = fill + 8'd1;
            done_cnt = done_cnt + 16'd1;
            if (fill >= rec_len) begin
                close_line(ck_acc);
                fill = '0;
                ck_acc = '0;
            end
        end else begin
            if (done_cnt < cfg_total) return;
            // close a record left open by a lowered byte count
            if (fill != 8'd0) begin
                close_line(ck_acc);
                fill = '0;
                ck_acc = '0;
            end
            end_addr = cfg_start + done_cnt;
            emit(hrse_pkg::CHAR_COLON);
            emit_str("04000003");
            emit_hex(cfg_start[15:8]);
            emit_hex(cfg_start[7:0]);
            emit_hex(end_addr[15:8]);
            emit_hex(end_addr[7:0]);
            sum = hrse_pkg::END_REC_SUM + cfg_start[15:8] + cfg_start[7:0]
                + end_addr[15:8] + end_addr[7:0];
            close_line(sum);
            emit(hrse_pkg::CHAR_COLON);
            emit_str("00000001FF");
            emit(hrse_pkg::CHAR_CR);
            emit(hrse_pkg::CHAR_LF);
            dump_closed = 1'b1;
        end
    endfunction

    function void cfg_row(input logic [1:0] idx, input logic [15:0] val);
        plan_q.push_back('{ROW_CFG, 1'b0, idx, val});
        plan_txt.push_back("");
    endfunction

    // txt "-" means the row is predicted, anything else is the literal text
    function void word_row(input bit kind, input logic [7:0] b, input string txt);
        plan_q.push_back('{ROW_WORD, kind, 2'd0, {8'd0, b}});
        plan_txt.push_back(txt);
    endfunction

    function void drain_row();
        plan_q.push_back('{ROW_DRAIN, 1'b0, 2'd0, 16'd0});
        plan_txt.push_back("");
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_cfg(idx, val);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_word(input bit kind, input logic [7:0] b, input string typed);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        encode_word(kind, b);
        if (typed == "-") begin
            foreach (step_text[i]) begin
                expect_q.push_back('{step_text[i], i == step_text.size() - 1});
            end
        end else begin
            for (int i = 0; i < typed.len(); i++) begin
                expect_q.push_back('{typed[i], i == typed.len() - 1});
            end
        end
    endtask

    // Hold off until all text is out, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expect_q.size() == 0) begin
                flag_error($sformatf("unexpected word: char %02h last %0b",
                                     m_text_char, m_last));
            end else begin
                exp_c = expect_q.pop_front();
                chars_checked++;
                if (m_text_char !== exp_c.ch || m_last !== exp_c.is_last) begin
                    flag_error($sformatf("mismatch: expected char %02h last %0b, got %02h last %0b",
                                         exp_c.ch, exp_c.is_last, m_text_char, m_last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0]  bpl;
        logic [15:0] base;
        int          seg_len;
        int          accepted;
        int          r;

        // fresh block: byte count is zero, so a data byte is surplus
        word_row(KIND_DATA, 8'h00, "");
        drain_row();
        cfg_row(hrse_pkg::CFG_BYTES_PER_LINE, 16'h0001);
        cfg_row(hrse_pkg::CFG_TOTAL_COUNT, 16'h0003);
        cfg_row(hrse_pkg::CFG_START_ADDRESS, 16'hFFFF);
        cfg_row(CFG_UNUSED, 16'hFFFF);
        word_row(KIND_END, 8'hFF, "");
        word_row(KIND_DATA, 8'hFF, ":01FFFF00FF02\015\012");
        word_row(KIND_DATA, 8'h00, ":0100000000FF\015\012");
        drain_row();
        cfg_row(hrse_pkg::CFG_BYTES_PER_LINE, 16'h0000);
        word_row(KIND_DATA, 8'hA5, ":01000100A559\015\012");
        word_row(KIND_DATA, 8'h3C, "");
        drain_row();
        cfg_row(hrse_pkg::CFG_BYTES_PER_LINE, 16'h0004);
        cfg_row(hrse_pkg::CFG_TOTAL_COUNT, 16'd12);
        cfg_row(hrse_pkg::CFG_START_ADDRESS, 16'h8000);
        word_row(KIND_DATA, 8'h01, "-");
        word_row(KIND_DATA, 8'h80, "-");
        drain_row();
        // change line size and base with a record open
        cfg_row(hrse_pkg::CFG_BYTES_PER_LINE, 16'h0002);
        cfg_row(hrse_pkg::CFG_START_ADDRESS, 16'h0100);
        word_row(KIND_DATA, 8'h7F, "-");
        word_row(KIND_DATA, 8'hFE, "-");
        word_row(KIND_DATA, 8'h55, "-");
        word_row(KIND_END, 8'h00, "");
        word_row(KIND_DATA, 8'hAA, "-");
        word_row(KIND_DATA, 8'h0F, "-");
        word_row(KIND_DATA, 8'hF0, "-");
        word_row(KIND_DATA, 8'h33, "-");
        word_row(KIND_DATA, 8'hC3, "");

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan_q[i]) begin
            case (plan_q[i].op)
                ROW_CFG:  cfg_write(plan_q[i].idx, plan_q[i].val);
                ROW_WORD: send_word(plan_q[i].kind, plan_q[i].val[7:0], plan_txt[i]);
                default:  drain();
            endcase
        end

        for (int seg = 0; seg < 12; seg++) begin
            case (seg / 4)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 87;
                end
                1: begin
                    send_idle_pct = 87;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain();
            r = $urandom_range(0, 99);
            if (r < 10) begin
                bpl = 8'd0;
            end else if (r < 25) begin
                bpl = 8'd1;
            end else if (r < 45) begin
                bpl = 8'($urandom_range(2, 4));
            end else if (r < 90) begin
                bpl = 8'($urandom_range(5, 16));
            end else begin
                bpl = 8'($urandom_range(17, 40));
            end
            r = $urandom_range(0, 99);
            if (r < 20) begin
                base = 16'h0000;
            end else if (r < 40) begin
                base = 16'hFFFF;
            end else begin
                base = 16'($urandom_range(0, 65535));
            end
            seg_len = $urandom_range(20, 34);
            // upper byte of the line size write is don't-care
            cfg_write(hrse_pkg::CFG_BYTES_PER_LINE, {8'($urandom_range(0, 255)), bpl});
            cfg_write(hrse_pkg::CFG_START_ADDRESS, base);
            cfg_write(hrse_pkg::CFG_TOTAL_COUNT, done_cnt + 16'(seg_len));
            accepted = 0;
            while (accepted < seg_len) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_word(KIND_END, 8'($urandom_range(0, 255)), "-");
                end else begin
                    send_word(KIND_DATA, 8'($urandom_range(0, 255)), "-");
                    accepted++;
                    rand_bytes++;
                end
            end
            // surplus bytes past the byte count
            repeat ($urandom_range(0, 2)) send_word(KIND_DATA, 8'($urandom_range(0, 255)), "-");
        end

        // longest records, then close the dump with a record still open
        send_idle_pct = 20;
        recv_idle_pct = 87;
        drain();
        cfg_write(hrse_pkg::CFG_BYTES_PER_LINE, 16'h00FF);
        cfg_write(hrse_pkg::CFG_TOTAL_COUNT, 16'hFFFF);
        cfg_write(hrse_pkg::CFG_START_ADDRESS, 16'hFFFF - 16'($urandom_range(0, 300)));
        repeat (20) send_word(KIND_DATA, 8'($urandom_range(0, 255)), "-");
        drain();
        cfg_write(hrse_pkg::CFG_TOTAL_COUNT, done_cnt);
        send_word(KIND_DATA, 8'hFF, "");
        send_word(KIND_END, 8'h00, "-");
        send_word(KIND_DATA, 8'h5A, "");
        send_word(KIND_END, 8'hFF, "");
        drain();

        $display("run covered %0d input words (%0d random data bytes) and %0d register writes",
                 words_sent, rand_bytes, cfg_writes);
        $display("%0d text characters compared, line sizes 0 to 255, end records included",
                 chars_checked);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
